[design/first_fit_arena_offset_allocator_defines.svh]
// assertion macros used by the checker file
`ifndef FIRST_FIT_ARENA_OFFSET_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ARENA_OFFSET_ALLOCATOR_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define FFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds during reset
`define FFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/ffa_pkg.sv]
// shared types and constants of the first-fit arena offset allocator
package ffa_pkg;

  localparam int MAX_ACTIVE       = 16;
  localparam int OFFSET_BITS      = 32;
  localparam int TICK_BITS        = 16;
  localparam int IDX_W            = $clog2(MAX_ACTIVE);
  localparam int CNT_W            = $clog2(MAX_ACTIVE + 1);
  localparam int SIZE_W           = 31;
  localparam int SUM_W            = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
  localparam int ELEM_SHIFT       = 2;
  localparam int ALIGN_LOG2_MAX   = 12;
  localparam int ALIGN_LOG2_RESET = 5;
  localparam int ADDR_W           = 3;

  typedef logic [OFFSET_BITS-1:0] off_t;
  typedef logic [TICK_BITS-1:0]   tick_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [SIZE_W-1:0]      size_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_DYNAMIC  = 2'd1,
    ERR_FULL     = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_SLOT,
    ST_SCAN,
    ST_PLACE,
    ST_DONE
  } state_e;

  typedef enum logic [ADDR_W-3:0] {
    REG_ALIGN_LOG2 = 1'b0
  } reg_e;

  typedef struct packed {
    off_t  start_off;
    off_t  end_off;
    tick_t free_tick;
  } entry_t;

  typedef struct packed {
    logic   clr_all;
    logic   clr_one;
    idx_t   clr_idx;
    logic   wr_en;
    idx_t   wr_idx;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_idx;
  } tbl_req_t;

endpackage

[design/ffa_table.sv]
// active entry table: entry memory with registered read and per-entry valid flags
module ffa_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ffa_pkg::tbl_req_t                 req_i,
  output logic [ffa_pkg::MAX_ACTIVE-1:0]    valid_o,
  output ffa_pkg::entry_t                   rdata_o
);

  logic [ffa_pkg::MAX_ACTIVE-1:0] valid_q, valid_d;
  ffa_pkg::entry_t                mem_q [ffa_pkg::MAX_ACTIVE];
  ffa_pkg::entry_t                rdata_q;

  always_comb begin
    valid_d = valid_q;
    if (req_i.clr_all) begin
      valid_d = '0;
    end
    if (req_i.clr_one) begin
      valid_d[req_i.clr_idx] = 1'b0;
    end
    if (req_i.wr_en) begin
      valid_d[req_i.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // reads and writes never share a cycle, so no bypass is needed
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_idx];
    end
  end

  assign valid_o = valid_q;
  assign rdata_o = rdata_q;

endmodule

[design/ffa_engine.sv]
// allocation sequencer: free sweep, slot pick, ordered first-fit scan, placement
module ffa_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [3:0]                        align_log2_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              new_run_i,
  input  logic [15:0]                       start_tick_i,
  input  logic [15:0]                       end_tick_i,
  input  logic [27:0]                       element_count_i,
  input  logic                              is_dynamic_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [31:0]                       offset_o,
  output logic [30:0]                       aligned_size_o,
  output logic [31:0]                       peak_size_o,
  output logic [1:0]                        error_code_o,
  output ffa_pkg::tbl_req_t                 tbl_req_o,
  input  logic [ffa_pkg::MAX_ACTIVE-1:0]    tbl_valid_i,
  input  ffa_pkg::entry_t                   tbl_rdata_i
);

  localparam logic [ffa_pkg::CNT_W-1:0] CntEnd = ffa_pkg::CNT_W'(ffa_pkg::MAX_ACTIVE);

  ffa_pkg::state_e state_q, state_d;
  ffa_pkg::tick_t  start_q, start_d, endt_q, endt_d;
  ffa_pkg::size_t  size_q, size_d;
  ffa_pkg::off_t   peak_q, peak_d, cur_q, cur_d;
  logic            prev_found_q, prev_found_d;
  ffa_pkg::off_t   prev_s_q, prev_s_d, prev_e_q, prev_e_d;
  ffa_pkg::idx_t   prev_idx_q, prev_idx_d;
  logic            best_found_q, best_found_d;
  ffa_pkg::off_t   best_s_q, best_s_d, best_e_q, best_e_d;
  ffa_pkg::idx_t   best_idx_q, best_idx_d;
  ffa_pkg::idx_t   slot_q, slot_d;
  logic [ffa_pkg::CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic            rd_v_q, rd_v_d;
  ffa_pkg::idx_t   rd_a_q, rd_a_d;
  ffa_pkg::off_t   res_off_q, res_off_d;
  ffa_pkg::size_t  res_size_q, res_size_d;
  ffa_pkg::err_e   res_err_q, res_err_d;
  logic            out_valid_q, out_valid_d;
  ffa_pkg::off_t   out_off_q, out_off_d, out_peak_q, out_peak_d;
  ffa_pkg::size_t  out_size_q, out_size_d;
  ffa_pkg::err_e   out_err_q, out_err_d;

  logic                 issuing, sweep_done, hit, after_prev, before_best, fits;
  logic                 free_found;
  ffa_pkg::idx_t        free_idx;
  logic [3:0]           lg;
  ffa_pkg::size_t       mask, new_size;
  logic [ffa_pkg::SUM_W-1:0] sum;

  always_comb begin
    lg       = (align_log2_i > 4'(ffa_pkg::ALIGN_LOG2_MAX)) ?
               4'(ffa_pkg::ALIGN_LOG2_MAX) : align_log2_i;
    mask     = (ffa_pkg::SIZE_W'(1) << lg) - ffa_pkg::SIZE_W'(1);
    new_size = ((ffa_pkg::SIZE_W'(element_count_i) << ffa_pkg::ELEM_SHIFT) + mask) & ~mask;
  end

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ffa_pkg::MAX_ACTIVE - 1; i >= 0; i--) begin
      if (!tbl_valid_i[i]) begin
        free_found = 1'b1;
        free_idx   = ffa_pkg::IDX_W'(i);
      end
    end
  end

  // scan order is (start offset, end offset, slot)
  always_comb begin
    hit = rd_v_q && tbl_valid_i[rd_a_q];
    after_prev = !prev_found_q || (tbl_rdata_i.start_off > prev_s_q) ||
                 ((tbl_rdata_i.start_off == prev_s_q) &&
                  ((tbl_rdata_i.end_off > prev_e_q) ||
                   ((tbl_rdata_i.end_off == prev_e_q) && (rd_a_q > prev_idx_q))));
    before_best = !best_found_q || (tbl_rdata_i.start_off < best_s_q) ||
                  ((tbl_rdata_i.start_off == best_s_q) &&
                   ((tbl_rdata_i.end_off < best_e_q) ||
                    ((tbl_rdata_i.end_off == best_e_q) && (rd_a_q < best_idx_q))));
    sum  = ffa_pkg::SUM_W'(cur_q) + ffa_pkg::SUM_W'(size_q);
    fits = sum <= ffa_pkg::SUM_W'(best_s_q);
  end

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    endt_d       = endt_q;
    size_d       = size_q;
    peak_d       = peak_q;
    cur_d        = cur_q;
    prev_found_d = prev_found_q;
    prev_s_d     = prev_s_q;
    prev_e_d     = prev_e_q;
    prev_idx_d   = prev_idx_q;
    best_found_d = best_found_q;
    best_s_d     = best_s_q;
    best_e_d     = best_e_q;
    best_idx_d   = best_idx_q;
    slot_d       = slot_q;
    res_off_d    = res_off_q;
    res_size_d   = res_size_q;
    res_err_d    = res_err_q;
    out_off_d    = out_off_q;
    out_size_d   = out_size_q;
    out_peak_d   = out_peak_q;
    out_err_d    = out_err_q;
    out_valid_d  = out_valid_q && out_stall_i;

    issuing    = (rd_cnt_q != CntEnd) &&
                 ((state_q == ffa_pkg::ST_FREE) || (state_q == ffa_pkg::ST_SCAN));
    sweep_done = (rd_cnt_q == CntEnd) && !rd_v_q;
    rd_cnt_d   = issuing ? rd_cnt_q + ffa_pkg::CNT_W'(1) : rd_cnt_q;
    rd_v_d     = issuing;
    rd_a_d     = rd_cnt_q[ffa_pkg::IDX_W-1:0];

    tbl_req_o         = '0;
    tbl_req_o.rd_en   = issuing;
    tbl_req_o.rd_idx  = rd_cnt_q[ffa_pkg::IDX_W-1:0];
    tbl_req_o.clr_idx = rd_a_q;
    tbl_req_o.wr_idx  = slot_q;
    tbl_req_o.wr_data = '{start_off: cur_q, end_off: sum[ffa_pkg::OFFSET_BITS-1:0],
                          free_tick: endt_q};

    case (state_q)
      ffa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          start_d = ffa_pkg::TICK_BITS'(start_tick_i);
          endt_d  = ffa_pkg::TICK_BITS'(end_tick_i);
          size_d  = new_size;
          if (new_run_i) begin
            tbl_req_o.clr_all = 1'b1;
            peak_d            = '0;
          end
          if (is_dynamic_i) begin
            res_off_d  = '0;
            res_size_d = '0;
            res_err_d  = ffa_pkg::ERR_DYNAMIC;
            state_d    = ffa_pkg::ST_DONE;
          end else begin
            rd_cnt_d = '0;
            state_d  = ffa_pkg::ST_FREE;
          end
        end
      end
      ffa_pkg::ST_FREE: begin
        if (hit && (tbl_rdata_i.free_tick <= start_q)) begin
          tbl_req_o.clr_one = 1'b1;
        end
        if (sweep_done) begin
          state_d = ffa_pkg::ST_SLOT;
        end
      end
      ffa_pkg::ST_SLOT: begin
        if (!free_found) begin
          res_off_d  = '0;
          res_size_d = size_q;
          res_err_d  = ffa_pkg::ERR_FULL;
          state_d    = ffa_pkg::ST_DONE;
        end else begin
          slot_d       = free_idx;
          cur_d        = '0;
          prev_found_d = 1'b0;
          best_found_d = 1'b0;
          rd_cnt_d     = '0;
          state_d      = ffa_pkg::ST_SCAN;
        end
      end
      ffa_pkg::ST_SCAN: begin
        if (hit && after_prev && before_best) begin
          best_found_d = 1'b1;
          best_s_d     = tbl_rdata_i.start_off;
          best_e_d     = tbl_rdata_i.end_off;
          best_idx_d   = rd_a_q;
        end
        if (sweep_done) begin
          if (!best_found_q || fits) begin
            state_d = ffa_pkg::ST_PLACE;
          end else begin
            // gap too small: step past this entry and sweep again
            cur_d        = best_e_q;
            prev_found_d = 1'b1;
            prev_s_d     = best_s_q;
            prev_e_d     = best_e_q;
            prev_idx_d   = best_idx_q;
            best_found_d = 1'b0;
            rd_cnt_d     = '0;
          end
        end
      end
      ffa_pkg::ST_PLACE: begin
        res_size_d = size_q;
        if (sum[ffa_pkg::SUM_W-1:ffa_pkg::OFFSET_BITS] != '0) begin
          res_off_d = '0;
          res_err_d = ffa_pkg::ERR_OVERFLOW;
        end else begin
          tbl_req_o.wr_en = 1'b1;
          res_off_d       = cur_q;
          res_err_d       = ffa_pkg::ERR_OK;
          if (sum[ffa_pkg::OFFSET_BITS-1:0] > peak_q) begin
            peak_d = sum[ffa_pkg::OFFSET_BITS-1:0];
          end
        end
        state_d = ffa_pkg::ST_DONE;
      end
      ffa_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_off_d   = res_off_q;
          out_size_d  = res_size_q;
          out_peak_d  = peak_q;
          out_err_d   = res_err_q;
          state_d     = ffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ffa_pkg::ST_IDLE;
      peak_q       <= '0;
      rd_cnt_q     <= CntEnd;
      rd_v_q       <= 1'b0;
      prev_found_q <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      peak_q       <= peak_d;
      rd_cnt_q     <= rd_cnt_d;
      rd_v_q       <= rd_v_d;
      prev_found_q <= prev_found_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    endt_q     <= endt_d;
    size_q     <= size_d;
    cur_q      <= cur_d;
    prev_s_q   <= prev_s_d;
    prev_e_q   <= prev_e_d;
    prev_idx_q <= prev_idx_d;
    best_s_q   <= best_s_d;
    best_e_q   <= best_e_d;
    best_idx_q <= best_idx_d;
    slot_q     <= slot_d;
    rd_a_q     <= rd_a_d;
    res_off_q  <= res_off_d;
    res_size_q <= res_size_d;
    res_err_q  <= res_err_d;
    out_off_q  <= out_off_d;
    out_size_q <= out_size_d;
    out_peak_q <= out_peak_d;
    out_err_q  <= out_err_d;
  end

  assign in_stall_o     = (state_q != ffa_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign offset_o       = 32'(out_off_q);
  assign aligned_size_o = 31'(out_size_q);
  assign peak_size_o    = 32'(out_peak_q);
  assign error_code_o   = out_err_q;

endmodule

[design/first_fit_arena_offset_allocator.sv]
// First-fit arena offset allocator. Each accepted item is one live interval; the block
// returns one result item with its byte offset, aligned size, run peak and error code.
// Steps per item, with N = 16 table entries and k entries live after freeing: accept,
// a free sweep over the entry memory (N reads, then the registered read data drains),
// a slot pick, then one ordered scan sweep for each entry stepped past plus the final
// one (at most k+1 sweeps), placement, and the load of the output register. A full
// table ends after the slot pick; a dynamic-shape item goes from accept straight to
// the output register. A stalled result that still waits in the output register holds
// the next result back. The next item is taken while the previous result still waits
// in the output register. Alignment is set at APB address 0 and must be written only
// while the block is idle; the block itself does not enforce this.
module first_fit_arena_offset_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffa_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          new_run_i,
  input  logic [15:0]                   start_tick_i,
  input  logic [15:0]                   end_tick_i,
  input  logic [27:0]                   element_count_i,
  input  logic                          is_dynamic_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   offset_o,
  output logic [30:0]                   aligned_size_o,
  output logic [31:0]                   peak_size_o,
  output logic [1:0]                    error_code_o
);

  logic [3:0]                     align_q, align_d;
  logic                           sel_align;
  ffa_pkg::tbl_req_t              tbl_req;
  logic [ffa_pkg::MAX_ACTIVE-1:0] tbl_valid;
  ffa_pkg::entry_t                tbl_rdata;

  assign sel_align = (paddr[ffa_pkg::ADDR_W-1:2] == ffa_pkg::REG_ALIGN_LOG2);
  assign pready    = 1'b1;
  assign prdata    = sel_align ? 32'(align_q) : 32'd0;

  always_comb begin
    align_d = align_q;
    if (psel && penable && pwrite && pready && sel_align) begin
      align_d = pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= 4'(ffa_pkg::ALIGN_LOG2_RESET);
    end else begin
      align_q <= align_d;
    end
  end

  ffa_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .valid_o (tbl_valid),
    .rdata_o (tbl_rdata)
  );

  ffa_engine u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .align_log2_i    (align_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .new_run_i       (new_run_i),
    .start_tick_i    (start_tick_i),
    .end_tick_i      (end_tick_i),
    .element_count_i (element_count_i),
    .is_dynamic_i    (is_dynamic_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .offset_o        (offset_o),
    .aligned_size_o  (aligned_size_o),
    .peak_size_o     (peak_size_o),
    .error_code_o    (error_code_o),
    .tbl_req_o       (tbl_req),
    .tbl_valid_i     (tbl_valid),
    .tbl_rdata_i     (tbl_rdata)
  );

endmodule

[design/ffa_checker.sv]
// port-level checks of the allocator, bound to the top level
`include "first_fit_arena_offset_allocator_defines.svh"

module ffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] offset_o,
  input logic [30:0] aligned_size_o,
  input logic [31:0] peak_size_o,
  input logic [1:0]  error_code_o
);

  logic        res_ok, res_rejected;
  logic [32:0] buf_top;

  assign res_ok       = out_valid_o && (error_code_o == ffa_pkg::ERR_OK);
  assign res_rejected = out_valid_o && (error_code_o != ffa_pkg::ERR_OK);
  assign buf_top      = {1'b0, offset_o} + {2'b00, aligned_size_o};

  `FFA_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")
  `FFA_ASSERT(a_result_held, out_valid_o && out_stall_i |=> out_valid_o, "stalled result lost")
  `FFA_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "item not taken")
  `FFA_ASSERT(a_within_peak, res_ok |-> buf_top <= {1'b0, peak_size_o}, "buffer beyond peak")
  `FFA_ASSERT(a_error_zero_offset, res_rejected |-> offset_o == 32'd0, "rejected item placed")

endmodule

bind first_fit_arena_offset_allocator ffa_checker u_ffa_checker (.*);

[test/tb.sv]
// testbench for the first-fit arena offset allocator: random intervals checked against a predictor
module tb;

  typedef struct packed {
    logic        new_run;
    logic [15:0] t_first;
    logic [15:0] t_last;
    logic [27:0] elem_cnt;
    logic        is_dynamic;
  } interval_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [30:0] size_bytes;
    logic [31:0] peak_size;
    logic [1:0]  error_code;
  } placement_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ffa_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        new_run_i = 1'b0;
  logic [15:0] start_tick_i = '0;
  logic [15:0] end_tick_i = '0;
  logic [27:0] element_count_i = '0;
  logic        is_dynamic_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] offset_o;
  logic [30:0] aligned_size_o;
  logic [31:0] peak_size_o;
  logic [1:0]  error_code_o;

  first_fit_arena_offset_allocator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]  align_lg;
  logic        slot_live [ffa_pkg::MAX_ACTIVE];
  logic [63:0] slot_lo [ffa_pkg::MAX_ACTIVE];
  logic [63:0] slot_hi [ffa_pkg::MAX_ACTIVE];
  logic [15:0] slot_free [ffa_pkg::MAX_ACTIVE];
  logic [63:0] arena_peak;

  interval_t  pending_q[$];
  placement_t placement_q[$];
  int errors = 0;
  int placed = 0;
  int err_seen [4];
  int cycle = 0;
  bit quiet = 1'b0;
  bit hold_sender = 1'b0;
  int accepted = 0;

  function automatic placement_t place_interval(interval_t it);
    placement_t r;
    int lg, slot, best, prev;
    logic [63:0] sz, cur, ps, pe, align;
    logic after;
    r = '0;
    lg = (align_lg > ffa_pkg::ALIGN_LOG2_MAX) ? ffa_pkg::ALIGN_LOG2_MAX : align_lg;
    align = 64'd1 << lg;
    slot = -1;
    prev = -1;
    ps = 0;
    pe = 0;
    if (it.new_run) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      arena_peak = 0;
    end
    if (it.is_dynamic) begin
      r.peak_size = arena_peak[31:0];
      r.error_code = ffa_pkg::ERR_DYNAMIC;
      return r;
    end
    foreach (slot_live[i])
      if (slot_live[i] && slot_free[i] <= it.t_first) slot_live[i] = 1'b0;
    sz = ({36'd0, it.elem_cnt} * 4 + align - 1) & ~(align - 1);
    r.size_bytes = sz[30:0];
    r.peak_size = arena_peak[31:0];
    for (int i = 0; i < ffa_pkg::MAX_ACTIVE; i++)
      if (!slot_live[i]) begin
        slot = i;
        break;
      end
    if (slot < 0) begin
      r.error_code = ffa_pkg::ERR_FULL;
      return r;
    end
    cur = 0;
    forever begin
      best = -1;
      for (int i = 0; i < ffa_pkg::MAX_ACTIVE; i++) begin
        if (!slot_live[i]) continue;
        after = slot_lo[i] > ps || (slot_lo[i] == ps &&
                (slot_hi[i] > pe || (slot_hi[i] == pe && i > prev)));
        if (prev >= 0 && !after) continue;
        if (best < 0 || slot_lo[i] < slot_lo[best] ||
            (slot_lo[i] == slot_lo[best] && (slot_hi[i] < slot_hi[best] ||
            (slot_hi[i] == slot_hi[best] && i < best))))
          best = i;
      end
      if (best < 0) break;
      if (cur + sz <= slot_lo[best]) break;
      cur = slot_hi[best];
      prev = best;
      ps = slot_lo[best];
      pe = slot_hi[best];
    end
    if (cur + sz > 64'hFFFF_FFFF) begin
      r.error_code = ffa_pkg::ERR_OVERFLOW;
      return r;
    end
    slot_live[slot] = 1'b1;
    slot_lo[slot] = cur;
    slot_hi[slot] = cur + sz;
    slot_free[slot] = it.t_last;
    if (cur + sz > arena_peak) arena_peak = cur + sz;
    r.offset = cur[31:0];
    r.peak_size = arena_peak[31:0];
    r.error_code = ffa_pkg::ERR_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, placed);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) accepted <= accepted + 1;
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() > 0 && !hold_sender && (quiet || $urandom_range(99) >= 17))
        begin
          interval_t it;
          it = pending_q.pop_front();
          placement_q.insert(placement_q.size(), place_interval(it));
          in_valid_i <= 1'b1;
          new_run_i <= it.new_run;
          start_tick_i <= it.t_first;
          end_tick_i <= it.t_last;
          element_count_i <= it.elem_cnt;
          is_dynamic_i <= it.is_dynamic;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 17);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (placement_q.size() == 0) begin
        report_mismatch("unexpected result", offset_o, 0);
      end else begin
        placement_t w;
        w = placement_q.pop_front();
        if (offset_o !== w.offset) report_mismatch("offset", offset_o, w.offset);
        if (aligned_size_o !== w.size_bytes)
          report_mismatch("size", {1'b0, aligned_size_o}, {1'b0, w.size_bytes});
        if (peak_size_o !== w.peak_size) report_mismatch("peak_size", peak_size_o, w.peak_size);
        if (error_code_o !== w.error_code)
          report_mismatch("error_code", {30'd0, error_code_o}, {30'd0, w.error_code});
        err_seen[w.error_code]++;
      end
      placed++;
    end
  end

  always @(posedge clk_i) begin
    if (cycle > 4000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_align(logic [3:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ffa_pkg::REG_ALIGN_LOG2, 2'b00};
    pwdata <= {$urandom_range(1) ? 28'hFFFFFFF : 28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    align_lg = v;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || placement_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic add(logic nr, logic [15:0] s, logic [15:0] e, logic [27:0] c, logic d);
    interval_t it;
    it = '{nr, s, e, c, d};
    pending_q.insert(pending_q.size(), it);
  endtask

  // one schedule of intervals with nondecreasing start ticks
  task automatic add_run(int n, int max_count, int dyn_pct);
    logic [15:0] t;
    t = 16'($urandom_range(200));
    for (int k = 0; k < n; k++) begin
      t = t + 16'($urandom_range(3));
      add(k == 0, t, t + 16'($urandom_range(1, 40)), 28'($urandom_range(max_count)),
          $urandom_range(99) < dyn_pct);
    end
  endtask

  initial begin
    align_lg = 4'(ffa_pkg::ALIGN_LOG2_RESET);
    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      slot_lo[i] = 0;
      slot_hi[i] = 0;
      slot_free[i] = 0;
    end
    arena_peak = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero size, dynamic, extremes, table full
    add(1'b1, 16'd0, 16'd5, 28'd0, 1'b0);
    add(1'b0, 16'd0, 16'd5, 28'd1, 1'b0);
    add(1'b0, 16'd0, 16'hFFFF, 28'hFFFFFFF, 1'b0);
    add(1'b0, 16'd1, 16'hFFFF, 28'hFFFFFFF, 1'b0);
    add(1'b0, 16'd1, 16'hFFFF, 28'hFFFFFFF, 1'b0);
    add(1'b0, 16'd2, 16'd10, 28'd7, 1'b1);
    add(1'b0, 16'hFFFF, 16'hFFFF, 28'd3, 1'b0);
    add(1'b1, 16'd0, 16'd0, 28'h5555555, 1'b0);
    add(1'b0, 16'd0, 16'd9, 28'h2AAAAAA, 1'b1);
    for (int k = 0; k < 17; k++) add(k == 0, 16'd10, 16'd100, k[27:0] + 28'd1, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_align(4'd0);
        1: write_align(4'd12);
        2: write_align(4'd15);
        3: write_align(4'd3);
        4: write_align(4'd13);
        default: write_align(4'd5);
      endcase
      quiet = (ph == 3);
      for (int r = 0; r < 10; r++) begin
        if (r == 5 && ph == 2) begin
          drain();
          hold_sender = 1'b1;
          repeat (50) @(posedge clk_i);
          hold_sender = 1'b0;
        end
        case ($urandom_range(9))
          0: add_run(20, 28'hFFFFFFF, 5);
          1: add_run(20, 28'h7FFFFFF, 10);
          default: add_run(20, 5000, 8);
        endcase
        // noise: arbitrary fields out of order within the run
        if ($urandom_range(3) == 0)
          add(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 28'($urandom),
              1'($urandom_range(1)));
      end
      drain();
    end
    repeat (400) @(posedge clk_i);
    $display("covered %0d items and %0d results over the reset alignment and six writes:",
             accepted, placed);
    $display("ok %0d, dynamic %0d, table full %0d, offset overflow %0d",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    if (errors == 0 && placement_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+design
design/ffa_pkg.sv
design/ffa_table.sv
design/ffa_engine.sv
design/first_fit_arena_offset_allocator.sv
design/ffa_checker.sv
test/tb.sv
